### src/dktd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dktd_pkg: shared types for the dual-key timed debouncer
// Request and response payloads, key phase encodings and reset constants.
// ----------------------------------------------------------------------------
package dktd_pkg;

   localparam int unsigned TimeWidth   = 32;
   localparam int unsigned WindowWidth = 16;

   localparam logic [WindowWidth-1:0] WindowResetMs = WindowWidth'(20);

   typedef struct packed {
      logic [TimeWidth-1:0] now_ms;
      logic                 key1_change_seen;
      logic                 key2_rise_seen;
      logic                 key1_pin_level;
      logic                 key2_pin_level;
   } req_payload_type;

   typedef struct packed {
      logic key1_edge_pulse;
      logic key2_press_pulse;
      logic key1_is_high;
   } rsp_payload_type;

   typedef enum logic {
      K1_IDLE     = 1'b0,
      K1_DEBOUNCE = 1'b1
   } key1_phase_type;

   // Code 3 is never entered; it acts as idle for the rise flag.
   typedef enum logic [1:0] {
      K2_IDLE      = 2'd0,
      K2_DEBOUNCE  = 2'd1,
      K2_CONFIRMED = 2'd2
   } key2_phase_type;

endpackage

### src/dual_key_timed_debouncer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_key_timed_debouncer_top: two-key debouncer with a millisecond window
// One request per key update call, one response per request.
// ----------------------------------------------------------------------------
//  channel | ports                          | handshake       | payload
//  --------+--------------------------------+-----------------+------------------
//  request | req_valid/req_ready/req_payload| valid & ready   | req_payload_type
//  response| rsp_valid/rsp_ready/rsp_payload| valid & ready   | rsp_payload_type
//  config  | csr_write_enable/csr_write_data| enable, no wait | 16-bit window ms
//
//  A request is captured in an input register, then evaluated against the
//  key state and written to the response register; one request per cycle
//  is sustained while responses are not stalled.
//  The evaluation path is one 32-bit subtract and compare per key.
//  A stalled response holds the stage behind it; req_ready drops only when
//  both registers are full and rsp_ready is low.
//  Synchronous reset clears key state, valid flags and sets the window to 20.
// ----------------------------------------------------------------------------
module dual_key_timed_debouncer_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  dktd_pkg::req_payload_type    req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output dktd_pkg::rsp_payload_type    rsp_payload,
   input  logic                         csr_write_enable,
   input  logic [dktd_pkg::WindowWidth-1:0] csr_write_data
);
   import dktd_pkg::*;

   logic                   window_ff;
   logic [WindowWidth-1:0] window_ms_ff;

   logic            stage_valid_ff;
   req_payload_type stage_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;

   key1_phase_type       key1_phase_ff, key1_phase_in, key1_phase_mid;
   logic [TimeWidth-1:0] key1_start_ff, key1_start_in;
   logic                 key1_stable_ff, key1_stable_in;
   key2_phase_type       key2_phase_ff, key2_phase_in, key2_phase_mid;
   logic [TimeWidth-1:0] key2_start_ff, key2_start_in;

   logic                 advance;
   logic                 key1_open, key2_open;
   logic [TimeWidth-1:0] key1_elapsed, key2_elapsed;
   logic                 key1_due, key2_due;

   // Load the window on every write.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ms_ff <= WindowResetMs;
         window_ff    <= 1'b0;
      end else if (csr_write_enable) begin
         window_ms_ff <= csr_write_data;
         window_ff    <= 1'b1;
      end
   end

   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Apply edge flags first: an idle key enters debounce stamped with now.
   assign key1_open = stage_ff.key1_change_seen && (key1_phase_ff == K1_IDLE);
   assign key2_open = stage_ff.key2_rise_seen &&
                      (key2_phase_ff != K2_DEBOUNCE) && (key2_phase_ff != K2_CONFIRMED);

   assign key1_phase_mid = key1_open ? K1_DEBOUNCE : key1_phase_ff;
   assign key2_phase_mid = key2_open ? K2_DEBOUNCE : key2_phase_ff;
   assign key1_start_in  = key1_open ? stage_ff.now_ms : key1_start_ff;
   assign key2_start_in  = key2_open ? stage_ff.now_ms : key2_start_ff;

   // Wrapping differences against the window.
   assign key1_elapsed = stage_ff.now_ms - key1_start_in;
   assign key2_elapsed = stage_ff.now_ms - key2_start_in;
   assign key1_due = (key1_phase_mid == K1_DEBOUNCE) &&
                     (key1_elapsed >= TimeWidth'(window_ms_ff));
   assign key2_due = (key2_phase_mid == K2_DEBOUNCE) &&
                     (key2_elapsed >= TimeWidth'(window_ms_ff));

   // Next state
   always_comb begin
      key1_phase_in  = key1_phase_mid;
      key1_stable_in = key1_stable_ff;
      if (key1_due) begin
         key1_phase_in  = K1_IDLE;
         key1_stable_in = stage_ff.key1_pin_level;
      end

      key2_phase_in = key2_phase_mid;
      unique case (key2_phase_mid)
         K2_DEBOUNCE: begin
            if (key2_due) begin
               key2_phase_in = stage_ff.key2_pin_level ? K2_CONFIRMED : K2_IDLE;
            end
         end
         K2_CONFIRMED: begin
            if (!stage_ff.key2_pin_level) begin
               key2_phase_in = K2_IDLE;
            end
         end
         default: begin
            key2_phase_in = key2_phase_mid;
         end
      endcase
   end

   // Outputs
   always_comb begin
      rsp_in.key1_edge_pulse  = key1_due && (stage_ff.key1_pin_level != key1_stable_ff);
      rsp_in.key2_press_pulse = key2_due && stage_ff.key2_pin_level;
      rsp_in.key1_is_high     = key1_stable_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         key1_phase_ff  <= K1_IDLE;
         key1_start_ff  <= '0;
         key1_stable_ff <= 1'b0;
         key2_phase_ff  <= K2_IDLE;
         key2_start_ff  <= '0;
      end else begin
         if (req_ready) begin
            stage_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff   <= 1'b1;
            key1_phase_ff  <= key1_phase_in;
            key1_start_ff  <= key1_start_in;
            key1_stable_ff <= key1_stable_in;
            key2_phase_ff  <= key2_phase_in;
            key2_start_ff  <= key2_start_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: hold while stalled.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // A key 1 edge pulse must flip the stored stable level.
   a_key1_pulse_flips: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_in.key1_edge_pulse |=> key1_stable_ff != $past(key1_stable_ff))
      else $error("key 1 pulse without level change");

   // Without a pulse the stable level holds.
   a_key1_level_holds: assert property (@(posedge clock) disable iff (reset)
      !(advance && rsp_in.key1_edge_pulse) |=> $stable(key1_stable_ff))
      else $error("key 1 level changed without pulse");

   // A key 2 press leaves key 2 confirmed.
   a_key2_press_confirms: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_in.key2_press_pulse |=> key2_phase_ff == K2_CONFIRMED)
      else $error("key 2 press did not confirm");

   // Backpressure only when both registers are full and the sink stalls.
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> stage_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("request stalled without cause");

   // Window register tracks the last write.
   a_window_write: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> window_ff && window_ms_ff == $past(csr_write_data))
      else $error("window write lost");

endmodule
